// ----- src/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at the rising clock edge, skipped while reset is high.
`define LISU_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Check a property at the rising clock edge, reset cycles included.
`define LISU_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

// ----- src/lisu_pkg.sv -----
// Shared types and constants of the infection lattice block.
`default_nettype none

package lisu_pkg;

   localparam int ACTION_W    = 2;
   localparam int COORD_IN_W  = 7;
   localparam int STATE_W     = 3;
   localparam int RADIUS_W    = 4;
   localparam int COUNT_OUT_W = 15;
   localparam int NSTATES     = 5;

   localparam logic [STATE_W-1:0] ST_O  = 3'd0;
   localparam logic [STATE_W-1:0] ST_V  = 3'd1;
   localparam logic [STATE_W-1:0] ST_LA = 3'd2;
   localparam logic [STATE_W-1:0] ST_UA = 3'd3;
   localparam logic [STATE_W-1:0] ST_N  = 3'd4;

   localparam logic [ACTION_W-1:0] ACT_WRITE  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_UPDATE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_READ   = 2'd2;

   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 4'd1;

   typedef struct packed {
      logic                en;
      logic [STATE_W-1:0]  old_st;
      logic [STATE_W-1:0]  new_st;
   } cnt_upd_type;

endpackage

`default_nettype wire

// ----- src/lattice_infection_site_update.sv -----
// Top level of the toroidal infection lattice with per-state counts.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_ready   action, site_x, site_y, write_value
//   rsp      out        rsp_valid/rsp_ready   cell_value and five state counts
//   csr      in         csr_valid/csr_ready   signal_radius
//
// A read or write passes through the reduce, lookup, decide, final read and final
// states; reduce repeats while either coordinate is at least SIDE, subtracting SIDE
// from each such coordinate. An update from a V or N site first steps to the window
// corner, then scans the (2r+1)^2 window cells, adding a modify step per cell inside
// the radius other than the site itself (r zero skips the scan); that step rewrites
// an O or LA cell. After reset a clearing pass writes all SIDE*SIDE cells before the
// first item is taken. One item is in work at a time; a finished result waits in
// the output register; the sequencer waits in S_FINAL while it is full and unread.
`default_nettype none

module lattice_infection_site_update #(
   parameter int SIDE       = 128,
   parameter int RADIUS_MAX = 15
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [lisu_pkg::ACTION_W-1:0]         req_action,
   input  wire logic [lisu_pkg::COORD_IN_W-1:0]       req_site_x,
   input  wire logic [lisu_pkg::COORD_IN_W-1:0]       req_site_y,
   input  wire logic [lisu_pkg::STATE_W-1:0]          req_write_value,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic [lisu_pkg::STATE_W-1:0]               rsp_cell_value,
   output logic [lisu_pkg::COUNT_OUT_W-1:0]           rsp_count_naive,
   output logic [lisu_pkg::COUNT_OUT_W-1:0]           rsp_count_infected,
   output logic [lisu_pkg::COUNT_OUT_W-1:0]           rsp_count_weak_antiviral,
   output logic [lisu_pkg::COUNT_OUT_W-1:0]           rsp_count_full_antiviral,
   output logic [lisu_pkg::COUNT_OUT_W-1:0]           rsp_count_signalling,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [lisu_pkg::RADIUS_W-1:0]         csr_signal_radius
);

   localparam int AWD = $clog2(SIDE * SIDE);
   localparam int CNW = $clog2(SIDE * SIDE + 1);
   localparam int RW  = $clog2(RADIUS_MAX + 1);
   localparam int OCW = lisu_pkg::COUNT_OUT_W;

   logic [lisu_pkg::RADIUS_W-1:0]          radius_ff;
   logic [RW-1:0]                          radius_sat;
   logic                                   mem_wr_en;
   logic [AWD-1:0]                         mem_wr_addr;
   logic [AWD-1:0]                         mem_rd_addr;
   logic [lisu_pkg::STATE_W-1:0]           mem_wr_data;
   logic [lisu_pkg::STATE_W-1:0]           mem_rd_data;
   lisu_pkg::cnt_upd_type                  cnt_upd;
   logic [lisu_pkg::NSTATES-1:0][CNW-1:0]  counts;
   logic                                   fin_valid;
   logic                                   fin_ready;
   logic [lisu_pkg::STATE_W-1:0]           fin_cell;

   logic                                   rsp_valid_ff;
   logic [lisu_pkg::STATE_W-1:0]           cell_ff;
   logic [OCW-1:0]                         naive_ff, infected_ff, weak_ff, full_ff, signal_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= lisu_pkg::RADIUS_RESET;
      end else if (csr_valid && csr_ready) begin
         radius_ff <= csr_signal_radius;
      end
   end

   assign radius_sat = (32'(radius_ff) > RADIUS_MAX) ? RW'(RADIUS_MAX) : RW'(radius_ff);

   lisu_seq #(
      .SIDE       (SIDE),
      .RADIUS_MAX (RADIUS_MAX)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_site_x      (req_site_x),
      .req_site_y      (req_site_y),
      .req_write_value (req_write_value),
      .radius          (radius_sat),
      .mem_wr_en       (mem_wr_en),
      .mem_wr_addr     (mem_wr_addr),
      .mem_wr_data     (mem_wr_data),
      .mem_rd_addr     (mem_rd_addr),
      .mem_rd_data     (mem_rd_data),
      .cnt_upd         (cnt_upd),
      .fin_valid       (fin_valid),
      .fin_ready       (fin_ready),
      .fin_cell        (fin_cell)
   );

   lisu_lattice #(
      .SIDE (SIDE)
   ) u_lattice (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   lisu_counts #(
      .SIDE (SIDE)
   ) u_counts (
      .clock  (clock),
      .reset  (reset),
      .upd    (cnt_upd),
      .counts (counts)
   );

   assign fin_ready = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fin_valid && fin_ready) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (fin_valid && fin_ready) begin
         cell_ff     <= fin_cell;
         naive_ff    <= OCW'(counts[lisu_pkg::ST_O]);
         infected_ff <= OCW'(counts[lisu_pkg::ST_V]);
         weak_ff     <= OCW'(counts[lisu_pkg::ST_LA]);
         full_ff     <= OCW'(counts[lisu_pkg::ST_UA]);
         signal_ff   <= OCW'(counts[lisu_pkg::ST_N]);
      end
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_cell_value           = cell_ff;
   assign rsp_count_naive          = naive_ff;
   assign rsp_count_infected       = infected_ff;
   assign rsp_count_weak_antiviral = weak_ff;
   assign rsp_count_full_antiviral = full_ff;
   assign rsp_count_signalling     = signal_ff;

endmodule

`default_nettype wire

// ----- src/lisu_lattice.sv -----
// Lattice cell memory with one write port and one registered read port.
`default_nettype none

module lisu_lattice #(
   parameter int SIDE = 128
) (
   input  wire logic                            clock,
   input  wire logic                            wr_en,
   input  wire logic [$clog2(SIDE*SIDE)-1:0]    wr_addr,
   input  wire logic [lisu_pkg::STATE_W-1:0]    wr_data,
   input  wire logic [$clog2(SIDE*SIDE)-1:0]    rd_addr,
   output logic      [lisu_pkg::STATE_W-1:0]    rd_data
);

   localparam int DEPTH = SIDE * SIDE;

   logic [lisu_pkg::STATE_W-1:0] cells_ff [DEPTH];
   logic [lisu_pkg::STATE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cells_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= cells_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- src/lisu_counts.sv -----
// Running per-state cell counters.
`default_nettype none

module lisu_counts #(
   parameter int SIDE = 128
) (
   input  wire logic                                                   clock,
   input  wire logic                                                   reset,
   input  wire lisu_pkg::cnt_upd_type                                  upd,
   output logic [lisu_pkg::NSTATES-1:0][$clog2(SIDE*SIDE+1)-1:0]       counts
);

   localparam int CNW = $clog2(SIDE * SIDE + 1);

   logic [lisu_pkg::NSTATES-1:0][CNW-1:0] cnt_ff;
   logic [lisu_pkg::NSTATES-1:0][CNW-1:0] cnt_in;

   always_comb begin
      for (int k = 0; k < lisu_pkg::NSTATES; k++) begin
         cnt_in[k] = cnt_ff[k];
         if (upd.en) begin
            if (upd.old_st == lisu_pkg::STATE_W'(k) && cnt_ff[k] != '0) begin
               cnt_in[k] = cnt_in[k] - CNW'(1);
            end
            if (upd.new_st == lisu_pkg::STATE_W'(k)) begin
               cnt_in[k] = cnt_in[k] + CNW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < lisu_pkg::NSTATES; k++) begin
            if (k == int'(lisu_pkg::ST_O)) begin
               cnt_ff[k] <= CNW'(SIDE * SIDE);
            end else begin
               cnt_ff[k] <= '0;
            end
         end
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign counts = cnt_ff;

endmodule

`default_nettype wire

// ----- src/lisu_seq.sv -----
// Sequencer: clearing pass, site decode and neighbourhood walk.
`default_nettype none

module lisu_seq #(
   parameter int SIDE       = 128,
   parameter int RADIUS_MAX = 15
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [lisu_pkg::ACTION_W-1:0]         req_action,
   input  wire logic [lisu_pkg::COORD_IN_W-1:0]       req_site_x,
   input  wire logic [lisu_pkg::COORD_IN_W-1:0]       req_site_y,
   input  wire logic [lisu_pkg::STATE_W-1:0]          req_write_value,
   input  wire logic [$clog2(RADIUS_MAX+1)-1:0]       radius,
   output logic                                       mem_wr_en,
   output logic [$clog2(SIDE*SIDE)-1:0]               mem_wr_addr,
   output logic [lisu_pkg::STATE_W-1:0]               mem_wr_data,
   output logic [$clog2(SIDE*SIDE)-1:0]               mem_rd_addr,
   input  wire logic [lisu_pkg::STATE_W-1:0]          mem_rd_data,
   output lisu_pkg::cnt_upd_type                      cnt_upd,
   output logic                                       fin_valid,
   input  wire logic                                  fin_ready,
   output logic [lisu_pkg::STATE_W-1:0]               fin_cell
);

   localparam int XW  = $clog2(SIDE);
   localparam int AWD = $clog2(SIDE * SIDE);
   localparam int RDW = ((XW > lisu_pkg::COORD_IN_W) ? XW : lisu_pkg::COORD_IN_W) + 1;
   localparam int RW  = $clog2(RADIUS_MAX + 1);
   localparam int OW  = RW + 1;
   localparam int SQW = $clog2(2 * RADIUS_MAX * RADIUS_MAX + 1);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_REDUCE, S_LOOKUP, S_DECIDE,
      S_PREWRAP, S_SCAN, S_MODIFY, S_FINAL_RD, S_FINAL
   } seq_state_type;

   function automatic logic [XW-1:0] inc_wrap(input logic [XW-1:0] c);
      return (c == XW'(SIDE - 1)) ? '0 : c + XW'(1);
   endfunction

   function automatic logic [XW-1:0] dec_wrap(input logic [XW-1:0] c);
      return (c == '0) ? XW'(SIDE - 1) : c - XW'(1);
   endfunction

   function automatic logic [SQW-1:0] sq_next(input logic [SQW-1:0] sq,
                                              input logic signed [OW-1:0] d);
      logic signed [SQW+1:0] t;
      t = $signed({2'b00, sq}) + ((SQW+2)'(d) <<< 1) + (SQW+2)'(1);
      return SQW'(t);
   endfunction

   seq_state_type                 state_ff, state_in;
   logic [AWD-1:0]                clr_ff, clr_in;
   logic [lisu_pkg::ACTION_W-1:0] act_ff, act_in;
   logic [lisu_pkg::STATE_W-1:0]  wv_ff, wv_in;
   logic [RDW-1:0]                rx_ff, rx_in, ry_ff, ry_in;
   logic [XW-1:0]                 sx_ff, sx_in, sy_ff, sy_in;
   logic [XW-1:0]                 cx_ff, cx_in, cy_ff, cy_in, cy0_ff, cy0_in;
   logic [RW-1:0]                 r_ff, r_in, k_ff, k_in;
   logic [SQW-1:0]                rsq_ff, rsq_in;
   logic signed [OW-1:0]          dx_ff, dx_in, dy_ff, dy_in;
   logic [SQW-1:0]                dxsq_ff, dxsq_in, dysq_ff, dysq_in;
   logic [lisu_pkg::STATE_W-1:0]  fo_ff, fo_in, fa_ff, fa_in;

   logic [RW-1:0]                 r_sel;
   logic signed [OW-1:0]          rpos;
   logic [SQW-1:0]                dsq_sum;
   logic                          hit;
   logic [AWD-1:0]                cur_addr;

   assign rpos     = $signed({1'b0, r_ff});
   assign dsq_sum  = dxsq_ff + dysq_ff;
   assign hit      = (dsq_sum != '0) && (dsq_sum <= rsq_ff);
   assign cur_addr = AWD'(cx_ff) * AWD'(SIDE) + AWD'(cy_ff);

   assign req_ready   = (state_ff == S_IDLE);
   assign mem_rd_addr = cur_addr;
   assign fin_valid   = (state_ff == S_FINAL);
   assign fin_cell    = mem_rd_data;

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      act_in   = act_ff;
      wv_in    = wv_ff;
      rx_in    = rx_ff;
      ry_in    = ry_ff;
      sx_in    = sx_ff;
      sy_in    = sy_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      cy0_in   = cy0_ff;
      r_in     = r_ff;
      k_in     = k_ff;
      rsq_in   = rsq_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      dxsq_in  = dxsq_ff;
      dysq_in  = dysq_ff;
      fo_in    = fo_ff;
      fa_in    = fa_ff;
      r_sel    = '0;

      mem_wr_en   = 1'b0;
      mem_wr_addr = cur_addr;
      mem_wr_data = lisu_pkg::ST_O;
      cnt_upd     = '0;

      unique case (state_ff) inside
         S_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_ff;
            clr_in      = clr_ff + AWD'(1);
            if (clr_ff == AWD'(SIDE * SIDE - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               act_in   = req_action;
               wv_in    = req_write_value;
               rx_in    = RDW'(req_site_x);
               ry_in    = RDW'(req_site_y);
               state_in = S_REDUCE;
            end
         end
         S_REDUCE: begin
            if (rx_ff >= RDW'(SIDE) || ry_ff >= RDW'(SIDE)) begin
               if (rx_ff >= RDW'(SIDE)) begin
                  rx_in = rx_ff - RDW'(SIDE);
               end
               if (ry_ff >= RDW'(SIDE)) begin
                  ry_in = ry_ff - RDW'(SIDE);
               end
            end else begin
               sx_in    = XW'(rx_ff);
               sy_in    = XW'(ry_ff);
               cx_in    = XW'(rx_ff);
               cy_in    = XW'(ry_ff);
               state_in = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            state_in = S_FINAL_RD;
            if (act_ff == lisu_pkg::ACT_WRITE) begin
               if (wv_ff <= lisu_pkg::ST_N) begin
                  mem_wr_en      = 1'b1;
                  mem_wr_data    = wv_ff;
                  cnt_upd.en     = 1'b1;
                  cnt_upd.old_st = mem_rd_data;
                  cnt_upd.new_st = wv_ff;
               end
            end else if (act_ff == lisu_pkg::ACT_UPDATE) begin
               if (mem_rd_data == lisu_pkg::ST_V) begin
                  r_sel    = RW'(1);
                  fo_in    = lisu_pkg::ST_V;
                  fa_in    = lisu_pkg::ST_N;
                  state_in = S_PREWRAP;
               end else if (mem_rd_data == lisu_pkg::ST_N) begin
                  r_sel    = radius;
                  fo_in    = lisu_pkg::ST_LA;
                  fa_in    = lisu_pkg::ST_UA;
                  state_in = S_PREWRAP;
               end
               r_in   = r_sel;
               k_in   = r_sel;
               rsq_in = SQW'(r_sel) * SQW'(r_sel);
            end
         end
         S_PREWRAP: begin
            if (r_ff == '0) begin
               state_in = S_FINAL_RD;
            end else if (k_ff == '0) begin
               cy0_in   = cy_ff;
               dx_in    = -rpos;
               dy_in    = -rpos;
               dxsq_in  = rsq_ff;
               dysq_in  = rsq_ff;
               state_in = S_SCAN;
            end else begin
               cx_in = dec_wrap(cx_ff);
               cy_in = dec_wrap(cy_ff);
               k_in  = k_ff - RW'(1);
            end
         end
         S_SCAN, S_MODIFY: begin
            if (state_ff == S_MODIFY) begin
               if (mem_rd_data == lisu_pkg::ST_O) begin
                  mem_wr_en      = 1'b1;
                  mem_wr_data    = fo_ff;
                  cnt_upd.en     = 1'b1;
                  cnt_upd.old_st = mem_rd_data;
                  cnt_upd.new_st = fo_ff;
               end else if (mem_rd_data == lisu_pkg::ST_LA) begin
                  mem_wr_en      = 1'b1;
                  mem_wr_data    = fa_ff;
                  cnt_upd.en     = 1'b1;
                  cnt_upd.old_st = mem_rd_data;
                  cnt_upd.new_st = fa_ff;
               end
            end
            if (state_ff == S_SCAN && hit) begin
               state_in = S_MODIFY;
            end else begin
               state_in = S_SCAN;
               if (dy_ff == rpos) begin
                  if (dx_ff == rpos) begin
                     cx_in    = sx_ff;
                     cy_in    = sy_ff;
                     state_in = S_FINAL_RD;
                  end else begin
                     dxsq_in = sq_next(dxsq_ff, dx_ff);
                     dx_in   = dx_ff + OW'(1);
                     cx_in   = inc_wrap(cx_ff);
                     dy_in   = -rpos;
                     dysq_in = rsq_ff;
                     cy_in   = cy0_ff;
                  end
               end else begin
                  dysq_in = sq_next(dysq_ff, dy_ff);
                  dy_in   = dy_ff + OW'(1);
                  cy_in   = inc_wrap(cy_ff);
               end
            end
         end
         S_FINAL_RD: begin
            state_in = S_FINAL;
         end
         S_FINAL: begin
            if (fin_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
      act_ff  <= act_in;
      wv_ff   <= wv_in;
      rx_ff   <= rx_in;
      ry_ff   <= ry_in;
      sx_ff   <= sx_in;
      sy_ff   <= sy_in;
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      cy0_ff  <= cy0_in;
      r_ff    <= r_in;
      k_ff    <= k_in;
      rsq_ff  <= rsq_in;
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      dxsq_ff <= dxsq_in;
      dysq_ff <= dysq_in;
      fo_ff   <= fo_in;
      fa_ff   <= fa_in;
   end

endmodule

`default_nettype wire

// ----- src/lisu_checker.sv -----
// Port-level checker of the infection lattice block and its bind.
`default_nettype none
`include "assert_macros.svh"

module lisu_checker #(
   parameter int SIDE = 128
) (
   input wire logic                                  clock,
   input wire logic                                  reset,
   input wire logic                                  req_valid,
   input wire logic                                  req_ready,
   input wire logic                                  rsp_valid,
   input wire logic                                  rsp_ready,
   input wire logic [lisu_pkg::STATE_W-1:0]          rsp_cell_value,
   input wire logic [lisu_pkg::COUNT_OUT_W-1:0]      rsp_count_naive,
   input wire logic [lisu_pkg::COUNT_OUT_W-1:0]      rsp_count_infected,
   input wire logic [lisu_pkg::COUNT_OUT_W-1:0]      rsp_count_weak_antiviral,
   input wire logic [lisu_pkg::COUNT_OUT_W-1:0]      rsp_count_full_antiviral,
   input wire logic [lisu_pkg::COUNT_OUT_W-1:0]      rsp_count_signalling
);

   localparam int OCW = lisu_pkg::COUNT_OUT_W;

   logic [OCW-1:0] count_sum;

   assign count_sum = OCW'(rsp_count_naive + rsp_count_infected + rsp_count_weak_antiviral
                           + rsp_count_full_antiviral + rsp_count_signalling);

   `LISU_ASSERT_ALWAYS(a_clear_after_reset, clock, reset |=> !req_ready, "ready during clearing pass")

   `LISU_ASSERT(a_one_item, clock, reset, (req_valid && req_ready) |=> !req_ready, "second transfer accepted while busy")

   `LISU_ASSERT(a_count_total, clock, reset, rsp_valid |-> (count_sum == OCW'(SIDE * SIDE)), "state counts do not add up to lattice size")

   `LISU_ASSERT(a_cell_code, clock, reset, rsp_valid |-> (rsp_cell_value <= lisu_pkg::ST_N), "result cell holds an unused state code")

   `LISU_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_cell_value)), "stalled result dropped or changed")

endmodule

bind lattice_infection_site_update lisu_checker #(.SIDE(SIDE)) u_lisu_checker (.*);

`default_nettype wire
